>>> sv/ovle_pkg.sv
// ----------------------------------------------------------------------------
// Ordered value list engine package
// Sizes, request codes and the structs shared by the list engine modules.
// ----------------------------------------------------------------------------
package ovle_pkg;

  // Number of entries in the list store.
  localparam int unsigned CAPACITY = 64;
  // Entry index width and list count width (the count can hold CAPACITY).
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream payload.
  localparam int unsigned OPW  = 3;
  localparam int unsigned VW   = 32;
  localparam int unsigned POSW = 6;
  localparam int unsigned CNTW = 7;

  typedef logic [AW-1:0]   idx_t;
  typedef logic [CW-1:0]   cnt_t;
  typedef logic [VW-1:0]   val_t;
  typedef logic [OPW-1:0]  op_t;
  typedef logic [POSW-1:0] pos_out_t;
  typedef logic [CNTW-1:0] cnt_out_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // Request codes.
  localparam op_t OP_INS_TAIL = 3'd0;
  localparam op_t OP_INS_HEAD = 3'd1;
  localparam op_t OP_DELETE   = 3'd2;
  localparam op_t OP_SEARCH   = 3'd3;
  localparam op_t OP_MODIFY   = 3'd4;

  // Access to the entry store: one read address, one write address with
  // separate enables for the value and for each link field.
  typedef struct packed {
    logic rd_en;
    idx_t rd_addr;
    idx_t wr_addr;
    logic we_val;
    val_t wr_val;
    logic we_next;
    idx_t wr_next;
    logic we_prev;
    idx_t wr_prev;
  } mem_req_t;

  typedef struct packed {
    val_t val;
    idx_t next;
    idx_t prev;
  } mem_rsp_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    cnt_out_t count;
    logic     rejected;
    pos_out_t pos;
    logic     found;
  } result_t;

endpackage

>>> sv/ovle_store.sv
// ----------------------------------------------------------------------------
// Ordered value list entry store
// Value memory and link memory, synchronous read.
// ----------------------------------------------------------------------------
module ovle_store (
  input  logic              clk_i,
  input  ovle_pkg::mem_req_t req_i,
  output ovle_pkg::mem_rsp_t rsp_o
);

  localparam int unsigned AW = ovle_pkg::AW;

  // Link word: next in the low half, prev in the high half.
  ovle_pkg::val_t      val_mem  [ovle_pkg::CAPACITY];
  logic [2*AW-1:0]     link_mem [ovle_pkg::CAPACITY];

  ovle_pkg::val_t      rd_val_q;
  logic [2*AW-1:0]     rd_link_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we_val) begin
      val_mem[req_i.wr_addr] <= req_i.wr_val;
    end
    if (req_i.we_next) begin
      link_mem[req_i.wr_addr][AW-1:0] <= req_i.wr_next;
    end
    if (req_i.we_prev) begin
      link_mem[req_i.wr_addr][2*AW-1:AW] <= req_i.wr_prev;
    end
    if (req_i.rd_en) begin
      rd_val_q  <= val_mem[req_i.rd_addr];
      rd_link_q <= link_mem[req_i.rd_addr];
    end
  end

  assign rsp_o.val  = rd_val_q;
  assign rsp_o.next = rd_link_q[AW-1:0];
  assign rsp_o.prev = rd_link_q[2*AW-1:AW];

endmodule

>>> sv/ovle_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered value list controller
// Request sequencer: list walk, insert and unlink steps on the entry store.
// ----------------------------------------------------------------------------
module ovle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ovle_pkg::op_t       in_op_i,
  input  ovle_pkg::val_t      in_key_i,
  input  ovle_pkg::val_t      in_new_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output ovle_pkg::result_t   res_o,
  output ovle_pkg::mem_req_t  mem_req_o,
  input  ovle_pkg::mem_rsp_t  mem_rsp_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_FREE,
    ST_INS_LINK,
    ST_INS_NBR,
    ST_WALK,
    ST_DEL_A,
    ST_DEL_B,
    ST_DEL_FREE,
    ST_RESP
  } state_e;

  state_e              state_q;
  ovle_pkg::op_t       op_q;
  ovle_pkg::val_t      key_q;
  ovle_pkg::val_t      nv_q;
  ovle_pkg::idx_t      head_q;
  ovle_pkg::idx_t      tail_q;
  ovle_pkg::idx_t      free_q;
  ovle_pkg::cnt_t      count_q;
  ovle_pkg::cnt_t      fill_q;
  ovle_pkg::idx_t      cur_q;
  ovle_pkg::idx_t      pos_q;
  ovle_pkg::idx_t      nx_q;
  ovle_pkg::idx_t      pv_q;
  logic                found_q;
  logic                rej_q;

  logic                accept;
  logic                in_is_ins;
  logic                op_is_ins;
  logic                hit;
  logic                last_entry;

  // Free chain successor of an entry that was never allocated.
  function automatic ovle_pkg::idx_t wrap_inc(input ovle_pkg::idx_t x);
    logic [ovle_pkg::AW:0] s;
    s = {1'b0, x} + 1'b1;
    return (s >= (ovle_pkg::AW + 1)'(ovle_pkg::CAPACITY)) ? '0 : s[ovle_pkg::AW-1:0];
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_is_ins  = (in_op_i == ovle_pkg::OP_INS_TAIL) || (in_op_i == ovle_pkg::OP_INS_HEAD);
  assign op_is_ins  = (op_q == ovle_pkg::OP_INS_TAIL) || (op_q == ovle_pkg::OP_INS_HEAD);
  assign hit        = (mem_rsp_i.val == key_q);
  assign last_entry = ((ovle_pkg::cnt_t'(pos_q) + 1'b1) == count_q);

  assign res_valid_o = (state_q == ST_RESP) && out_free_i;
  assign res_o.found    = found_q;
  assign res_o.pos      = ovle_pkg::pos_out_t'(pos_q);
  assign res_o.rejected = rej_q;
  assign res_o.count    = ovle_pkg::cnt_out_t'(count_q);

  // Store accesses per step.
  always_comb begin
    mem_req_o = '0;
    case (state_q)
      ST_IDLE: begin
        mem_req_o.rd_en   = accept;
        mem_req_o.rd_addr = in_is_ins ? free_q : head_q;
      end
      ST_INS_LINK: begin
        mem_req_o.wr_addr = cur_q;
        mem_req_o.we_val  = 1'b1;
        mem_req_o.wr_val  = key_q;
        mem_req_o.we_next = 1'b1;
        mem_req_o.we_prev = 1'b1;
        if ((count_q != '0) && (op_q == ovle_pkg::OP_INS_TAIL)) begin
          mem_req_o.wr_prev = tail_q;
        end
        if ((count_q != '0) && (op_q == ovle_pkg::OP_INS_HEAD)) begin
          mem_req_o.wr_next = head_q;
        end
      end
      ST_INS_NBR: begin
        if (op_q == ovle_pkg::OP_INS_TAIL) begin
          mem_req_o.wr_addr = tail_q;
          mem_req_o.we_next = 1'b1;
          mem_req_o.wr_next = cur_q;
        end else begin
          mem_req_o.wr_addr = head_q;
          mem_req_o.we_prev = 1'b1;
          mem_req_o.wr_prev = cur_q;
        end
      end
      ST_WALK: begin
        // The next link feeds the read address directly: one entry a cycle.
        mem_req_o.rd_en   = !hit && !last_entry;
        mem_req_o.rd_addr = mem_rsp_i.next;
        mem_req_o.wr_addr = cur_q;
        mem_req_o.we_val  = hit && (op_q == ovle_pkg::OP_MODIFY);
        mem_req_o.wr_val  = nv_q;
      end
      ST_DEL_A: begin
        if (count_q == ovle_pkg::cnt_t'(1)) begin
          mem_req_o.we_next = 1'b0;
        end else if (cur_q == head_q) begin
          mem_req_o.wr_addr = nx_q;
          mem_req_o.we_prev = 1'b1;
        end else if (cur_q == tail_q) begin
          mem_req_o.wr_addr = pv_q;
          mem_req_o.we_next = 1'b1;
        end else begin
          mem_req_o.wr_addr = pv_q;
          mem_req_o.we_next = 1'b1;
          mem_req_o.wr_next = nx_q;
        end
      end
      ST_DEL_B: begin
        mem_req_o.wr_addr = nx_q;
        mem_req_o.we_prev = 1'b1;
        mem_req_o.wr_prev = pv_q;
      end
      ST_DEL_FREE: begin
        mem_req_o.wr_addr = cur_q;
        mem_req_o.we_next = 1'b1;
        mem_req_o.wr_next = free_q;
      end
      default: begin
        mem_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      key_q   <= '0;
      nv_q    <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      fill_q  <= '0;
      cur_q   <= '0;
      nx_q    <= '0;
      pv_q    <= '0;
      found_q <= 1'b0;
      rej_q   <= 1'b0;
      pos_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= in_op_i;
            key_q   <= in_key_i;
            nv_q    <= in_new_i;
            cur_q   <= head_q;
            found_q <= 1'b0;
            rej_q   <= 1'b0;
            pos_q   <= '0;
            if (in_is_ins) begin
              if (count_q >= ovle_pkg::CAP_CNT) begin
                rej_q   <= 1'b1;
                state_q <= ST_RESP;
              end else begin
                state_q <= ST_INS_FREE;
              end
            end else if ((in_op_i == ovle_pkg::OP_DELETE) ||
                         (in_op_i == ovle_pkg::OP_SEARCH) ||
                         (in_op_i == ovle_pkg::OP_MODIFY)) begin
              state_q <= (count_q == '0) ? ST_RESP : ST_WALK;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_INS_FREE: begin
          // Entries at or above the fill mark were never written; their link is implied.
          cur_q <= free_q;
          if (ovle_pkg::cnt_t'(free_q) < fill_q) begin
            free_q <= mem_rsp_i.next;
          end else begin
            free_q <= wrap_inc(free_q);
            fill_q <= fill_q + 1'b1;
          end
          state_q <= ST_INS_LINK;
        end
        ST_INS_LINK: begin
          if (count_q == '0) begin
            head_q  <= cur_q;
            tail_q  <= cur_q;
            count_q <= count_q + 1'b1;
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_INS_NBR;
          end
        end
        ST_INS_NBR: begin
          if (op_q == ovle_pkg::OP_INS_TAIL) begin
            tail_q <= cur_q;
          end else begin
            head_q <= cur_q;
          end
          count_q <= count_q + 1'b1;
          state_q <= ST_RESP;
        end
        ST_WALK: begin
          if (hit) begin
            found_q <= 1'b1;
            nx_q    <= mem_rsp_i.next;
            pv_q    <= mem_rsp_i.prev;
            state_q <= (op_q == ovle_pkg::OP_DELETE) ? ST_DEL_A : ST_RESP;
          end else if (last_entry) begin
            pos_q   <= '0;
            state_q <= ST_RESP;
          end else begin
            cur_q <= mem_rsp_i.next;
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_DEL_A: begin
          if (count_q == ovle_pkg::cnt_t'(1)) begin
            head_q  <= '0;
            tail_q  <= '0;
            state_q <= ST_DEL_FREE;
          end else if (cur_q == head_q) begin
            head_q  <= nx_q;
            state_q <= ST_DEL_FREE;
          end else if (cur_q == tail_q) begin
            tail_q  <= pv_q;
            state_q <= ST_DEL_FREE;
          end else begin
            state_q <= ST_DEL_B;
          end
        end
        ST_DEL_B: begin
          state_q <= ST_DEL_FREE;
        end
        ST_DEL_FREE: begin
          free_q  <= cur_q;
          count_q <= count_q - 1'b1;
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (op_is_ins && (state_q == ST_RESP)) begin
        rej_q <= rej_q;
      end
    end
  end

endmodule

>>> sv/ordered_value_list_engine_core.sv
// Throughput: one request at a time; the list walk visits one entry per cycle on the
//   store's read port.
// Reset: asynchronous, active low; the list is empty at once, no clearing pass is needed.
// ----------------------------------------------------------------------------
// Ordered value list engine
// Doubly linked list of signed 32-bit values held in a fixed entry store.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] key_value, [63:32] new_value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] operation
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] found, [6:1] match_position,
                                        // [7] insert_rejected, [14:8] entry_count,
                                        // [15] zero
);

  // The controller owns the list pointers, the count and the fill mark of
  // the store. Entries at or above the fill mark were never allocated, so their
  // free chain link is implied and the store itself needs no reset.
  ovle_pkg::mem_req_t mem_req;
  ovle_pkg::mem_rsp_t mem_rsp;
  ovle_pkg::result_t  res;
  logic               res_valid;
  logic               out_free;

  // Result register: a finished result waits here while the controller
  // goes back to idle and takes the next request transfer.
  logic               out_valid_q;
  ovle_pkg::result_t  out_data_q;

  assign out_free = !out_valid_q || m_axis_tready_i;

  ovle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (s_axis_tuser_i),
    .in_key_i    (s_axis_tdata_i[31:0]),
    .in_new_i    (s_axis_tdata_i[63:32]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp)
  );

  ovle_store u_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};

endmodule

>>> sv/ovle_checker.sv
// ----------------------------------------------------------------------------
// Ordered value list engine checker
// Port level assertions, bound to the engine top level.
// ----------------------------------------------------------------------------
module ovle_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_o
);

  localparam ovle_pkg::cnt_out_t FullCount = ovle_pkg::cnt_out_t'(ovle_pkg::CAPACITY);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  // One request at a time: no transfer right after an accepted one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in work");

  // A rejected insert reports a full list and no match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[7] |->
      (m_axis_tdata_o[14:8] == FullCount) && !m_axis_tdata_o[0])
    else $error("insert rejected without a full list");

endmodule

bind ordered_value_list_engine_core ovle_checker u_ovle_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

>>> sim/ovle_result_checker.sv
// ----------------------------------------------------------------------------
// List engine result checker
// Watches both stream channels. It keeps its own ordered copy of the list,
// works out the result of every accepted request and compares each result
// transfer with the oldest result still due.
// ----------------------------------------------------------------------------
module ovle_result_checker
  import ovle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [63:0] req_data_i,    // [31:0] key_value, [63:32] new_value
  input  logic [2:0]  req_user_i,    // [2:0] operation
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [15:0] res_data_i,    // [0] found, [6:1] match_position,
                                     // [7] insert_rejected, [14:8] entry_count
  output int          fail_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Values in list order, head first.
  val_t    list_values[$];
  // Results of accepted requests that have not been transferred yet.
  result_t due_results[$];
  int      mismatches = 0;

  assign fail_count_o = mismatches;

  initial outstanding_o = 0;

  // Applies one request to the list copy and returns the result it produces.
  function automatic result_t apply_request(op_t op, val_t key, val_t nv);
    result_t res;
    int      hit;
    res = '0;
    hit = -1;
    case (op)
      OP_INS_TAIL, OP_INS_HEAD: begin
        if (list_values.size() >= CAPACITY) begin
          res.rejected = 1'b1;
        end else if (op == OP_INS_TAIL) begin
          list_values.push_back(key);
        end else begin
          list_values.push_front(key);
        end
      end
      OP_DELETE, OP_SEARCH, OP_MODIFY: begin
        foreach (list_values[i]) begin
          if (hit < 0 && list_values[i] == key) hit = i;
        end
        if (hit >= 0) begin
          res.found = 1'b1;
          res.pos   = pos_out_t'(hit);
          if (op == OP_MODIFY) begin
            list_values[hit] = nv;
          end else if (op == OP_DELETE) begin
            list_values.delete(hit);
          end
        end
      end
      default: ;
    endcase
    res.count = cnt_out_t'(list_values.size());
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    result_t got;
    result_t want;
    if (rst_ni) begin
      // Results first, so a request accepted at the same edge cannot mask a
      // result that arrived with nothing due.
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i[14:0]);
        if (res_data_i[15] !== 1'b0) begin
          $error("pad: expected 0, actual %b", res_data_i[15]);
          mismatches++;
        end
        if (due_results.size() == 0) begin
          $error("result transfer with no request outstanding: %h", res_data_i);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            mismatches++;
          end
          if (got.pos !== want.pos) begin
            $error("match_position: expected %0d, actual %0d", want.pos, got.pos);
            mismatches++;
          end
          if (got.rejected !== want.rejected) begin
            $error("insert_rejected: expected %0d, actual %0d", want.rejected,
                   got.rejected);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, got.count);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        due_results.push_back(apply_request(op_t'(req_user_i), req_data_i[31:0],
                                            req_data_i[63:32]));
      end
    end
    outstanding_o <= due_results.size();
  end

endmodule

>>> sim/ordered_value_list_engine_core_tb.sv
// ----------------------------------------------------------------------------
// List engine testbench
// Drives requests into the list engine core: a directed opening over the
// edge cases, then random phases that fill, churn and drain the list, with
// random idling on both streams. The result checker judges every transfer.
// ----------------------------------------------------------------------------
module ordered_value_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ovle_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = CAPACITY + 8;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam val_t V_MAX  = 32'h7FFF_FFFF;
  localparam val_t V_MIN  = 32'h8000_0000;
  localparam val_t V_ONES = 32'hFFFF_FFFF;
  localparam val_t V_ZERO = 32'h0000_0000;

  // First code past the defined requests.
  localparam op_t OP_UNKNOWN = op_t'(OP_MODIFY + 1);

  // Request mix of a random phase.
  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_e;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;

  int fail_count;
  int outstanding;
  int cycle_count = 0;

  // Both sides run without idling while this is set.
  bit   steady = 1'b0;
  // Asks the receiver for one long hold-off.
  bit   hold_request = 1'b0;

  val_t key_pool[64];
  int   pool_size = 6;

  ordered_value_list_engine_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  ovle_result_checker i_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (s_tvalid),
    .req_ready_i   (s_axis_tready_o),
    .req_data_i    (s_tdata),
    .req_user_i    (s_tuser),
    .res_valid_i   (m_axis_tvalid_o),
    .res_ready_i   (m_tready),
    .res_data_i    (m_axis_tdata_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ordered_value_list_engine_core: FAILED **");
      $finish;
    end
  end

  // Result side: ready at random about 75 percent of the time, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Offers one request and returns at the edge where it is transferred.
  task automatic send_req(input op_t op, input val_t key, input val_t nv);
    if (!steady && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {nv, key};
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stops offering and waits until every due result has been transferred.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Mostly values from the current pool, so that lookups hit.
  function automatic val_t pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(pool_size - 1)];
    return val_t'($urandom);
  endfunction

  initial begin : stimulus
    int   sent;
    int   phase;
    int   phase_len;
    int   r;
    mix_e mix;
    op_t  op;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening. Lookups and an unknown code on the empty list.
    send_req(OP_SEARCH, 32'd5, val_t'($urandom));
    send_req(OP_DELETE, 32'd5, val_t'($urandom));
    send_req(OP_MODIFY, 32'd5, val_t'($urandom));
    send_req(OP_UNKNOWN, val_t'($urandom), val_t'($urandom));
    // Extremes at both ends: list becomes -1, min, max, 0.
    send_req(OP_INS_TAIL, V_MAX, val_t'($urandom));
    send_req(OP_INS_HEAD, V_MIN, val_t'($urandom));
    send_req(OP_INS_TAIL, V_ZERO, val_t'($urandom));
    send_req(OP_INS_HEAD, V_ONES, val_t'($urandom));
    send_req(OP_SEARCH, V_MAX, val_t'($urandom));
    // Modify creates a duplicate; the first match from the head must win.
    send_req(OP_MODIFY, V_MIN, V_ONES);
    send_req(OP_SEARCH, V_ONES, val_t'($urandom));
    send_req(OP_DELETE, V_ONES, val_t'($urandom));      // head
    send_req(OP_DELETE, V_ZERO, val_t'($urandom));      // tail
    send_req(op_t'(OP_MODIFY + 2), val_t'($urandom), val_t'($urandom));
    send_req(op_t'((1 << OPW) - 1), val_t'($urandom), val_t'($urandom));
    // Misses leave the list alone.
    send_req(OP_SEARCH, 32'd12345, val_t'($urandom));
    send_req(OP_MODIFY, 32'd12345, V_ZERO);
    send_req(OP_DELETE, 32'd12345, val_t'($urandom));
    // Middle delete, tail delete, then delete of the last entry.
    send_req(OP_INS_TAIL, 32'd42, val_t'($urandom));
    send_req(OP_DELETE, V_MAX, val_t'($urandom));
    send_req(OP_DELETE, 32'd42, val_t'($urandom));
    send_req(OP_DELETE, V_ONES, val_t'($urandom));
    // Insert into a list that was emptied by delete.
    send_req(OP_INS_HEAD, 32'd9, val_t'($urandom));
    send_req(OP_DELETE, 32'd9, val_t'($urandom));
    drain_results();

    // Random phases. The list carries over from one phase to the next, so
    // fill phases run it into the full store and drain phases empty it again.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mix       = mix_e'(phase % 3);
      pool_size = (phase % 2 != 0) ? 64 : 6;
      foreach (key_pool[i]) begin
        case ($urandom_range(9))
          0:       key_pool[i] = V_MIN;
          1:       key_pool[i] = V_MAX;
          2:       key_pool[i] = V_ONES;
          3:       key_pool[i] = V_ZERO;
          default: key_pool[i] = val_t'($urandom);
        endcase
      end
      // One long receiver hold-off while requests keep coming.
      if (phase == 1) hold_request = 1'b1;
      steady    = (phase == 3);
      phase_len = $urandom_range(80, 200);
      for (int n = 0; n < phase_len; n++) begin
        r = $urandom_range(99);
        case (mix)
          MIX_FILL: op = (r < 45) ? OP_INS_TAIL : (r < 80) ? OP_INS_HEAD :
                         (r < 85) ? OP_DELETE : (r < 92) ? OP_SEARCH :
                         (r < 97) ? OP_MODIFY : OP_UNKNOWN;
          MIX_CHURN: op = (r < 20) ? OP_INS_TAIL : (r < 40) ? OP_INS_HEAD :
                          (r < 60) ? OP_DELETE : (r < 78) ? OP_SEARCH :
                          (r < 96) ? OP_MODIFY : OP_UNKNOWN;
          default: op = (r < 8) ? OP_INS_TAIL : (r < 16) ? OP_INS_HEAD :
                        (r < 70) ? OP_DELETE : (r < 85) ? OP_SEARCH :
                        (r < 97) ? OP_MODIFY : OP_UNKNOWN;
        endcase
        // Unknown codes spread over all of them.
        if (op > OP_MODIFY) op = op_t'($urandom_range((1 << OPW) - 1, OP_MODIFY + 1));
        send_req(op, pick_key(), (op == OP_MODIFY) ? pick_key() : val_t'($urandom));
        if (op <= OP_MODIFY) sent++;
      end
      // Every other phase the sender pauses until all results are back.
      if (phase % 2 == 0) drain_results();
      phase++;
    end
    steady = 1'b0;

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** ordered_value_list_engine_core: PASSED **");
    end else begin
      $display("** ordered_value_list_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
